// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types for the sorted priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int ID_W     = 16;
    localparam int PRI_W    = 8;

    // Request commands.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_VIEW   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Operations broadcast to every cell.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } spq_entry_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } spq_cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and exchanges it with its
// neighbours on insert, pop and remove.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spq_pkg::spq_cell_ctl_t ctl,
    input  spq_pkg::spq_entry_t    prev,
    input  logic                   prev_ge,
    input  spq_pkg::spq_entry_t    next,
    input  logic                   found_in,
    output spq_pkg::spq_entry_t    cur,
    output logic                   ge,
    output logic                   found_out
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [spq_pkg::ID_W-1:0]  id_reg;
    logic [spq_pkg::ID_W-1:0]  id_next;
    logic [spq_pkg::PRI_W-1:0] pri_reg;
    logic [spq_pkg::PRI_W-1:0] pri_next;
    logic                      match;

    assign cur.valid = valid_reg;
    assign cur.id    = id_reg;
    assign cur.pri   = pri_reg;

    always_comb
    begin
        ge         = valid_reg && (pri_reg >= ctl.pri);
        match      = valid_reg && (id_reg == ctl.id);
        found_out  = found_in || match;
        valid_next = valid_reg;
        id_next    = id_reg;
        pri_next   = pri_reg;
        unique case (ctl.op)
            spq_pkg::OP_HOLD:
            begin
            end
            spq_pkg::OP_INSERT:
            begin
                // Cells ahead of the insertion point keep their entry; the
                // first cell behind it takes the new entry, the rest shift down.
                if (!ge)
                begin
                    if (prev_ge)
                    begin
                        valid_next = 1'b1;
                        id_next    = ctl.id;
                        pri_next   = ctl.pri;
                    end
                    else
                    begin
                        valid_next = prev.valid;
                        id_next    = prev.id;
                        pri_next   = prev.pri;
                    end
                end
            end
            spq_pkg::OP_POP:
            begin
                valid_next = next.valid;
                id_next    = next.id;
                pri_next   = next.pri;
            end
            spq_pkg::OP_REMOVE:
            begin
                // The matching cell and every cell behind it move up by one.
                if (found_out)
                begin
                    valid_next = next.valid;
                    id_next    = next.id;
                    pri_next   = next.pri;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

endmodule

// ===== rtl/sorted_priority_task_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Bounded priority queue held as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Entries live in a row of CAPACITY cells, head first, in descending priority
// with equal priorities in arrival order. Every cell compares against the
// request in parallel, so insert, pop and remove-by-id each take the request
// and register its single result at the same clock edge, and the next request
// can be taken as soon as that result has been collected. View presents one
// entry per cycle through the result register while the result is not stalled,
// and no request is taken until its last result is loaded.
// Nothing needs clearing after reset; the queue is empty at once.
module sorted_priority_task_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [1:0]                  command,
    input  logic [spq_pkg::ID_W-1:0]    task_id,
    input  logic [spq_pkg::PRI_W-1:0]   task_priority,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [1:0]                  status,
    output logic [spq_pkg::ID_W-1:0]    out_id,
    output logic [spq_pkg::PRI_W-1:0]   out_priority,
    output logic                        last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_VIEW = 1'b1;

    spq_pkg::spq_cell_ctl_t cell_ctl;
    spq_pkg::spq_entry_t    cell_q  [spq_pkg::CAPACITY];
    spq_pkg::spq_entry_t    prev_d  [spq_pkg::CAPACITY];
    spq_pkg::spq_entry_t    next_d  [spq_pkg::CAPACITY];
    logic                   ge_q    [spq_pkg::CAPACITY];
    logic                   prev_ge [spq_pkg::CAPACITY];
    logic                   found   [spq_pkg::CAPACITY+1];
    logic [spq_pkg::CAPACITY-1:0] valid_vec;

    logic                        state_reg;
    logic                        state_next;
    logic [spq_pkg::IDX_W-1:0]   idx_reg;
    logic [spq_pkg::IDX_W-1:0]   idx_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [spq_pkg::ID_W-1:0]    id_reg;
    logic [spq_pkg::ID_W-1:0]    id_next;
    logic [spq_pkg::PRI_W-1:0]   pri_reg;
    logic [spq_pkg::PRI_W-1:0]   pri_next;
    logic                        last_reg;
    logic                        last_next;

    logic cmd_accept;
    logic res_free;
    logic empty;
    logic full;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < spq_pkg::CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_d[i]  = '0;
            assign prev_ge[i] = 1'b1;
        end
        else
        begin : g_body
            assign prev_d[i]  = cell_q[i-1];
            assign prev_ge[i] = ge_q[i-1];
        end
        if (i == spq_pkg::CAPACITY - 1)
        begin : g_tail
            assign next_d[i] = '0;
        end
        else
        begin : g_link
            assign next_d[i] = cell_q[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .prev      (prev_d[i]),
            .prev_ge   (prev_ge[i]),
            .next      (next_d[i]),
            .found_in  (found[i]),
            .cur       (cell_q[i]),
            .ge        (ge_q[i]),
            .found_out (found[i+1])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    assign empty      = !cell_q[0].valid;
    assign full       = cell_q[spq_pkg::CAPACITY-1].valid;
    assign res_free   = !res_valid_reg || !res_stall;
    assign cmd_stall  = (state_reg == S_VIEW) || !res_free;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        cell_ctl.op  = spq_pkg::OP_HOLD;
        cell_ctl.id  = task_id;
        cell_ctl.pri = task_priority;
        if (cmd_accept)
        begin
            unique case (command)
                spq_pkg::CMD_INSERT: cell_ctl.op = full ? spq_pkg::OP_HOLD
                                                        : spq_pkg::OP_INSERT;
                spq_pkg::CMD_POP:    cell_ctl.op = empty ? spq_pkg::OP_HOLD
                                                         : spq_pkg::OP_POP;
                spq_pkg::CMD_REMOVE: cell_ctl.op = spq_pkg::OP_REMOVE;
                spq_pkg::CMD_VIEW:   cell_ctl.op = spq_pkg::OP_HOLD;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && res_stall;
        status_next    = status_reg;
        id_next        = id_reg;
        pri_next       = pri_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    status_next = spq_pkg::ST_OK;
                    id_next     = '0;
                    pri_next    = '0;
                    last_next   = 1'b1;
                    unique case (command)
                        spq_pkg::CMD_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = spq_pkg::ST_FULL;
                            end
                        end
                        spq_pkg::CMD_POP:
                        begin
                            res_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                id_next  = cell_q[0].id;
                                pri_next = cell_q[0].pri;
                            end
                        end
                        spq_pkg::CMD_REMOVE:
                        begin
                            res_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = spq_pkg::ST_EMPTY;
                            end
                            else if (!found[spq_pkg::CAPACITY])
                            begin
                                status_next = spq_pkg::ST_NOTFOUND;
                            end
                        end
                        spq_pkg::CMD_VIEW:
                        begin
                            if (empty)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_VIEW;
                                idx_next   = '0;
                            end
                        end
                    endcase
                end
            end
            S_VIEW:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = spq_pkg::ST_OK;
                    id_next        = cell_q[idx_reg].id;
                    pri_next       = cell_q[idx_reg].pri;
                    // The final entry is the one whose successor slot is empty.
                    last_next      = !next_d[idx_reg].valid;
                    idx_next       = idx_reg + 1'b1;
                    if (!next_d[idx_reg].valid)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        pri_reg    <= pri_next;
        last_reg   <= last_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign out_id       = id_reg;
    assign out_priority = pri_reg;
    assign last         = last_reg;

    // Occupied cells always form an unbroken run from the head.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && command == spq_pkg::CMD_POP && empty)
        |=> (res_valid && status == spq_pkg::ST_EMPTY && last))
        else $error("pop on an empty queue did not report empty");

    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && command == spq_pkg::CMD_INSERT && !full)
        |=> (!empty && res_valid && status == spq_pkg::ST_OK))
        else $error("insert into a non-full queue left it empty");

    a_view_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIEW) |-> cmd_stall)
        else $error("request taken while a view is in progress");

    a_view_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VIEW && res_free && !next_d[idx_reg].valid)
        |=> (state_reg == S_IDLE && res_valid && last))
        else $error("view did not end on its final entry");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority task queue. A table of
// directed requests runs first, then constrained random traffic that swings
// between filling and draining the queue, under four idling phases. Every
// result is compared field by field against typed expectations or a behavioural queue model.
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int RANDOM_PER_PHASE = 75;
    localparam int LONG_HOLD        = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PRINT_LIMIT      = 50;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic             last;
    } queue_result_t;

    typedef queue_result_t result_list_t[$];

    typedef struct {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        bit               typed;
        logic [1:0]       exp_status;
        logic [ID_W-1:0]  exp_id;
        logic [PRI_W-1:0] exp_pri;
        logic             exp_last;
    } request_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_stall;
    logic [1:0]       command;
    logic [ID_W-1:0]  task_id;
    logic [PRI_W-1:0] task_priority;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [1:0]       status;
    logic [ID_W-1:0]  out_id;
    logic [PRI_W-1:0] out_priority;
    logic             last;

    // Behavioural copy of the queue, head at index 0.
    logic [ID_W-1:0]  model_ids [CAPACITY];
    logic [PRI_W-1:0] model_pris[CAPACITY];
    int               model_count;

    queue_result_t    awaited_results[$];
    request_row_t     directed_rows[25];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_token;
    int hold_seen       = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int requests_by_cmd[4];
    int status_seen[4]  = '{default: 0};

    sorted_priority_task_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .task_id       (task_id),
        .task_priority (task_priority),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .out_id        (out_id),
        .out_priority  (out_priority),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Applies one request to the model queue and returns the results it causes.
    function automatic void model_command(input logic [1:0] c, input logic [ID_W-1:0] id,
                                          input logic [PRI_W-1:0] pri,
                                          output result_list_t res);
        int pos;
        int hit;
        res = {};
        hit = -1;
        case (c)
            CMD_INSERT:
            begin
                if (model_count >= CAPACITY)
                    res.push_back('{ST_FULL, '0, '0, 1'b1});
                else
                begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < model_count && model_pris[pos] >= pri)
                        pos++;
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_ids[i]  = model_ids[i-1];
                        model_pris[i] = model_pris[i-1];
                    end
                    model_ids[pos]  = id;
                    model_pris[pos] = pri;
                    model_count++;
                    res.push_back('{ST_OK, '0, '0, 1'b1});
                end
            end
            CMD_POP, CMD_REMOVE:
            begin
                if (model_count == 0)
                    res.push_back('{ST_EMPTY, '0, '0, 1'b1});
                else
                begin
                    if (c == CMD_POP)
                    begin
                        hit = 0;
                        res.push_back('{ST_OK, model_ids[0], model_pris[0], 1'b1});
                    end
                    else
                    begin
                        for (int i = model_count - 1; i >= 0; i--)
                            if (model_ids[i] == id)
                                hit = i;
                        res.push_back('{(hit < 0) ? ST_NOTFOUND : ST_OK, '0, '0, 1'b1});
                    end
                    if (hit >= 0)
                    begin
                        for (int i = hit; i + 1 < model_count; i++)
                        begin
                            model_ids[i]  = model_ids[i+1];
                            model_pris[i] = model_pris[i+1];
                        end
                        model_count--;
                    end
                end
            end
            default:
            begin
                if (model_count == 0)
                    res.push_back('{ST_EMPTY, '0, '0, 1'b1});
                else
                    for (int i = 0; i < model_count; i++)
                        res.push_back('{ST_OK, model_ids[i], model_pris[i],
                                        (i + 1 == model_count)});
            end
        endcase
    endfunction

    // Offers one request, waits for it to be taken and records what it should cause.
    task automatic offer_request(input request_row_t row);
        result_list_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        command       <= row.cmd;
        task_id       <= row.id;
        task_priority <= row.pri;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        model_command(row.cmd, row.id, row.pri, predicted);
        requests_by_cmd[row.cmd]++;
        if (row.typed)
            awaited_results.push_back('{row.exp_status, row.exp_id, row.exp_pri,
                                        row.exp_last});
        else
            foreach (predicted[i])
                awaited_results.push_back(predicted[i]);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Random traffic that swings between filling the queue and emptying it.
    task automatic run_random_requests(input int count);
        request_row_t row;
        bit           filling;
        int           roll;
        filling = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (model_count == CAPACITY)
                filling = 1'b0;
            else if (model_count == 0)
                filling = 1'b1;
            else if ($urandom_range(19) == 0)
                filling = !filling;
            roll      = $urandom_range(99);
            row       = '{default: '0};
            if (roll < 8)
                row.cmd = CMD_VIEW;
            else if (roll < (filling ? 68 : 30))
                row.cmd = CMD_INSERT;
            else if (roll < (filling ? 84 : 65))
                row.cmd = CMD_POP;
            else
                row.cmd = CMD_REMOVE;
            // Few distinct ids so that duplicates and matching removes are common.
            if ($urandom_range(1))
                row.id = ID_W'($urandom_range(7));
            else
                row.id = ID_W'($urandom);
            if (row.cmd == CMD_REMOVE && model_count > 0 && $urandom_range(9) < 6)
                row.id = model_ids[$urandom_range(model_count - 1)];
            roll = $urandom_range(9);
            if (roll < 4)
                row.pri = PRI_W'($urandom_range(3));
            else if (roll == 4)
                row.pri = '1;
            else
                row.pri = PRI_W'($urandom);
            offer_request(row);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < receiver_stall_pct);

        if (rst_n && res_valid && !res_stall)
        begin
            results_checked++;
            status_seen[status]++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d id %h pri %h last %b",
                                          status, out_id, out_priority, last));
            else
            begin
                queue_result_t want;
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (out_id !== want.id)
                    report_mismatch($sformatf("out_id %h, expected %h", out_id, want.id));
                if (out_priority !== want.pri)
                    report_mismatch($sformatf("out_priority %h, expected %h",
                                              out_priority, want.pri));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", last, want.last));
            end
        end
    end

    initial
    begin
        cmd_valid          <= 1'b0;
        command            <= CMD_INSERT;
        task_id            <= '0;
        task_priority      <= '0;
        rst_n              <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_token         = 0;
        model_count        = 0;
        requests_by_cmd    = '{default: 0};

        // Expected values are typed in where they are obvious; zero rows defer to the model.
        directed_rows = '{
            '{CMD_POP,    16'h0000, 8'h00, 1, ST_EMPTY,    16'h0000, 8'h00, 1'b1},
            '{CMD_REMOVE, 16'h5555, 8'h00, 1, ST_EMPTY,    16'h0000, 8'h00, 1'b1},
            '{CMD_VIEW,   16'h0000, 8'h00, 1, ST_EMPTY,    16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'hFFFF, 8'hFF, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0000, 8'h00, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h1234, 8'h80, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h1234, 8'h80, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_VIEW,   16'h0000, 8'h00, 0, ST_OK,       16'h0000, 8'h00, 1'b0},
            '{CMD_INSERT, 16'h8001, 8'h80, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h4002, 8'hFF, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h2003, 8'h00, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h1004, 8'h01, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0805, 8'hFE, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0406, 8'h7F, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0207, 8'h80, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0108, 8'h40, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h0089, 8'hC0, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h004A, 8'h80, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h002B, 8'h00, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'h001C, 8'h55, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_INSERT, 16'hBEEF, 8'h90, 1, ST_FULL,     16'h0000, 8'h00, 1'b1},
            '{CMD_VIEW,   16'h0000, 8'h00, 0, ST_OK,       16'h0000, 8'h00, 1'b0},
            '{CMD_REMOVE, 16'h1234, 8'h00, 1, ST_OK,       16'h0000, 8'h00, 1'b1},
            '{CMD_REMOVE, 16'h5555, 8'h00, 1, ST_NOTFOUND, 16'h0000, 8'h00, 1'b1},
            '{CMD_POP,    16'h0000, 8'h00, 1, ST_OK,       16'hFFFF, 8'hFF, 1'b1}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);

        // Hold results back for a long stretch while requests keep coming.
        hold_token = hold_token + 1;
        run_random_requests(RANDOM_PER_PHASE);
        drain_results();

        sender_idle_pct = 63;
        run_random_requests(RANDOM_PER_PHASE);
        drain_results();

        sender_idle_pct    = 0;
        receiver_stall_pct = 63;
        run_random_requests(RANDOM_PER_PHASE);
        drain_results();

        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
        run_random_requests(RANDOM_PER_PHASE);
        drain_results();

        // A view of a full queue is the longest job; any stray result shows up here.
        repeat (CAPACITY + 4) @(posedge clk);

        $display("Requests: %0d insert, %0d pop, %0d remove, %0d view; %0d results checked",
                 requests_by_cmd[CMD_INSERT], requests_by_cmd[CMD_POP],
                 requests_by_cmd[CMD_REMOVE], requests_by_cmd[CMD_VIEW], results_checked);
        $display("Statuses seen: %0d ok, %0d empty, %0d not found, %0d full; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
                 status_seen[ST_FULL], mismatch_count);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_task_queue.sv
test/testbench.sv
